// ===== sv/pal_pkg.sv =====
package pal_pkg;

    localparam int DATA_W    = 32;
    localparam int OP_W      = 3;
    localparam int POS_W     = 4;
    localparam int STAT_W    = 2;
    localparam int DEPTH_DEF = 8;

    localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE  = 3'd1;
    localparam logic [OP_W-1:0] OP_REVERSE = 3'd2;
    localparam logic [OP_W-1:0] OP_SEARCH  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ    = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BAD_POS  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [POS_W-1:0]  found;
        logic [DATA_W-1:0] value;
    } probe_t;

endpackage

// ===== sv/positional_array_list.sv =====
// Positional array list: DEPTH signed 32-bit entries, all zero after reset.
// Request channel: operation, position and item_value are taken at a rising
// edge with start high and busy low. Operations: insert, delete, reverse,
// search, read. Insert, delete and read need position in 1..DEPTH, else
// status reports a bad position and nothing changes.
// Result channel: done is high for one cycle with status, found_position and
// read_value valid in that cycle. The receiver cannot stall; each result is
// taken in its done cycle.
// Completion: insert, delete, reverse, rejected requests and unknown codes
// raise done from the execute state, at the edge on which every cell updates.
// Search and valid reads send a probe down the row of cells, one cell per
// cycle; done is registered once the probe leaves the last cell.
// busy is high from the request edge until the done cycle, in which a new
// request may already be taken.
// Reset (rst_n low, asynchronous) clears every entry and drops any request
// in flight.
module positional_array_list
    import pal_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [OP_W-1:0]          operation,
    input  logic [POS_W-1:0]         position,
    input  logic signed [DATA_W-1:0] item_value,
    output logic                     done,
    output logic [STAT_W-1:0]        status,
    output logic [POS_W-1:0]         found_position,
    output logic signed [DATA_W-1:0] read_value
);

    localparam int CLW = $clog2(DEPTH + 2);
    localparam int CW  = (CLW > POS_W) ? CLW : POS_W;
    localparam logic [CW-1:0] LIMIT = CW'(DEPTH);

    state_t            state_reg;
    state_t            state_next;
    req_t              req_reg;
    req_t              req_next;
    logic              done_reg;
    logic              done_next;
    logic [STAT_W-1:0] status_reg;
    logic [STAT_W-1:0] status_next;
    logic [POS_W-1:0]  found_reg;
    logic [POS_W-1:0]  found_next;
    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;

    logic              accept;
    logic              pos_ok;
    logic              probe_op;
    logic              apply;
    probe_t            probe_head;
    probe_t            probe_w [DEPTH+1];
    logic [DATA_W-1:0] entry_w [DEPTH];
    probe_t            last_probe;

    assign accept     = start && (state_reg == S_IDLE);
    assign pos_ok     = (CW'(req_reg.pos) != '0) && (CW'(req_reg.pos) <= LIMIT);
    assign probe_op   = (req_reg.op == OP_SEARCH) || ((req_reg.op == OP_READ) && pos_ok);
    assign last_probe = probe_w[DEPTH];

    always_comb
    begin
        probe_head       = '0;
        probe_head.valid = (state_reg == S_EXEC) && probe_op;
    end

    assign probe_w[0] = probe_head;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic [DATA_W-1:0] left_val;
            logic [DATA_W-1:0] right_val;

            if (g == 0)
            begin : g_first
                assign left_val = '0;
            end
            else
            begin : g_mid_l
                assign left_val = entry_w[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_last
                assign right_val = '0;
            end
            else
            begin : g_mid_r
                assign right_val = entry_w[g+1];
            end

            pal_cell #(
                .DEPTH (DEPTH),
                .INDEX (g)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .req        (req_reg),
                .apply      (apply),
                .left_val   (left_val),
                .right_val  (right_val),
                .mirror_val (entry_w[DEPTH-1-g]),
                .probe_in   (probe_w[g]),
                .probe_out  (probe_w[g+1]),
                .entry      (entry_w[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
                state_next = probe_op ? S_SCAN : S_IDLE;
            S_SCAN:
            begin
                if (last_probe.valid)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        req_next    = req_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        found_next  = found_reg;
        value_next  = value_reg;
        apply       = 1'b0;
        if (accept)
        begin
            req_next.op  = operation;
            req_next.pos = position;
            req_next.key = item_value;
        end
        case (state_reg)
            S_EXEC:
            begin
                apply = 1'b1;
                if (!probe_op)
                begin
                    done_next   = 1'b1;
                    found_next  = '0;
                    value_next  = '0;
                    status_next = STAT_OK;
                    if (((req_reg.op == OP_INSERT) || (req_reg.op == OP_DELETE)
                         || (req_reg.op == OP_READ)) && !pos_ok)
                        status_next = STAT_BAD_POS;
                end
            end
            S_SCAN:
            begin
                if (last_probe.valid)
                begin
                    done_next = 1'b1;
                    if (req_reg.op == OP_SEARCH)
                    begin
                        status_next = last_probe.hit ? STAT_OK : STAT_NOTFOUND;
                        found_next  = last_probe.hit ? last_probe.found : '0;
                        value_next  = '0;
                    end
                    else
                    begin
                        status_next = STAT_OK;
                        found_next  = '0;
                        value_next  = last_probe.value;
                    end
                end
            end
            default:
                apply = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            req_reg    <= '0;
            status_reg <= STAT_OK;
            found_reg  <= '0;
            value_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            req_reg    <= req_next;
            status_reg <= status_next;
            found_reg  <= found_next;
            value_reg  <= value_next;
        end
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign found_position = found_reg;
    assign read_value     = value_reg;

endmodule

// ===== sv/pal_cell.sv =====
module pal_cell
    import pal_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int INDEX = 0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  req_t              req,
    input  logic              apply,
    input  logic [DATA_W-1:0] left_val,
    input  logic [DATA_W-1:0] right_val,
    input  logic [DATA_W-1:0] mirror_val,
    input  probe_t            probe_in,
    output probe_t            probe_out,
    output logic [DATA_W-1:0] entry
);

    localparam int CLW = $clog2(DEPTH + 2);
    localparam int CW  = (CLW > POS_W) ? CLW : POS_W;
    localparam logic [CW-1:0] SELF  = CW'(INDEX + 1);
    localparam logic [CW-1:0] LIMIT = CW'(DEPTH);

    logic [DATA_W-1:0] entry_reg;
    logic [DATA_W-1:0] entry_next;
    probe_t            probe_reg;
    probe_t            probe_next;
    logic [CW-1:0]     pos_w;
    logic              pos_ok;

    assign pos_w  = CW'(req.pos);
    assign pos_ok = (pos_w != '0) && (pos_w <= LIMIT);

    always_comb
    begin
        entry_next = entry_reg;
        if (apply)
        begin
            case (req.op)
                OP_INSERT:
                begin
                    if (pos_ok && pos_w == SELF)
                        entry_next = req.key;
                    else if (pos_ok && pos_w < SELF)
                        entry_next = left_val;
                end
                OP_DELETE:
                begin
                    if (pos_ok && pos_w <= SELF)
                        entry_next = right_val;
                end
                OP_REVERSE:
                    entry_next = mirror_val;
                default:
                    entry_next = entry_reg;
            endcase
        end
    end

    always_comb
    begin
        probe_next = probe_in;
        if (probe_in.valid && !probe_in.hit)
        begin
            case (req.op)
                OP_SEARCH:
                begin
                    if (entry_reg == req.key)
                    begin
                        probe_next.hit   = 1'b1;
                        probe_next.found = POS_W'(INDEX + 1);
                    end
                end
                OP_READ:
                begin
                    if (pos_w == SELF)
                    begin
                        probe_next.hit   = 1'b1;
                        probe_next.value = entry_reg;
                    end
                end
                default:
                    probe_next = probe_in;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
            probe_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
            probe_reg <= probe_next;
        end
    end

    assign entry     = entry_reg;
    assign probe_out = probe_reg;

endmodule

// ===== dv/pal_list_checker.sv =====
module pal_list_checker
    import pal_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic [OP_W-1:0]          operation,
    input  logic [POS_W-1:0]         position,
    input  logic signed [DATA_W-1:0] item_value,
    input  logic                     done,
    input  logic [STAT_W-1:0]        status,
    input  logic [POS_W-1:0]         found_position,
    input  logic signed [DATA_W-1:0] read_value,
    output int                       mismatches,
    output int                       in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [STAT_W-1:0] stat;
        logic [POS_W-1:0]  found;
        logic [DATA_W-1:0] value;
    } answer_t;

    logic [DATA_W-1:0] slots [DEPTH];
    answer_t           awaited_answers [$];

    initial begin
        mismatches = 0;
        in_flight  = 0;
    end

    function automatic answer_t apply_to_list(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                              logic [DATA_W-1:0] val);
        answer_t           ans;
        logic              pos_valid;
        logic [DATA_W-1:0] held;
        int                slot;
        int                i;
        ans       = '0;
        pos_valid = (int'(pos) >= 1) && (int'(pos) <= DEPTH);
        slot      = int'(pos) - 1;
        case (op)
            OP_INSERT: begin
                if (!pos_valid)
                    ans.stat = STAT_BAD_POS;
                else
                begin
                    for (i = DEPTH - 1; i > slot; i--)
                        slots[i] = slots[i-1];
                    slots[slot] = val;
                end
            end
            OP_DELETE: begin
                if (!pos_valid)
                    ans.stat = STAT_BAD_POS;
                else
                begin
                    for (i = slot; i < DEPTH - 1; i++)
                        slots[i] = slots[i+1];
                    slots[DEPTH-1] = '0;
                end
            end
            OP_REVERSE: begin
                for (i = 0; i < DEPTH / 2; i++)
                begin
                    held               = slots[i];
                    slots[i]           = slots[DEPTH-1-i];
                    slots[DEPTH-1-i]   = held;
                end
            end
            OP_SEARCH: begin
                ans.stat = STAT_NOTFOUND;
                for (i = 0; i < DEPTH; i++)
                begin
                    if (ans.stat == STAT_NOTFOUND && slots[i] == val)
                    begin
                        ans.stat  = STAT_OK;
                        ans.found = POS_W'(i + 1);
                    end
                end
            end
            OP_READ: begin
                if (!pos_valid)
                    ans.stat = STAT_BAD_POS;
                else
                    ans.value = slots[slot];
            end
            default: ;
        endcase
        return ans;
    endfunction

    task automatic flag_mismatch(string what, answer_t want);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: expected status %0d found %0d value %h, got status %0d found %0d value %h",
                     $time, what, want.stat, want.found, want.value,
                     status, found_position, read_value);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        answer_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                slots[i] = '0;
            awaited_answers.delete();
        end
        else
        begin
            if (done)
            begin
                if (awaited_answers.size() == 0)
                    flag_mismatch("result with no request outstanding", '0);
                else
                begin
                    want = awaited_answers.pop_front();
                    if (status !== want.stat || found_position !== want.found ||
                        read_value !== want.value)
                        flag_mismatch("result mismatch", want);
                end
            end
            if (start && !busy)
                awaited_answers.push_back(apply_to_list(operation, position, item_value));
        end
        in_flight = awaited_answers.size();
    end

endmodule

// ===== dv/positional_array_list_test.sv =====
module positional_array_list_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pal_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int RANDOM_ITEMS = 950;
    localparam int CALM_ITEMS   = 150;
    localparam int CYCLE_LIMIT  = 400000;

    logic                     clk        = 1'b0;
    logic                     rst_n      = 1'b0;
    logic                     start      = 1'b0;
    logic [OP_W-1:0]          operation  = '0;
    logic [POS_W-1:0]         position   = '0;
    logic signed [DATA_W-1:0] item_value = '0;
    logic                     busy;
    logic                     done;
    logic [STAT_W-1:0]        status;
    logic [POS_W-1:0]         found_position;
    logic signed [DATA_W-1:0] read_value;

    int                mismatches;
    int                in_flight;
    int                cycles = 0;
    logic [DATA_W-1:0] value_pool [12];

    positional_array_list #(
        .DEPTH (DEPTH)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .position       (position),
        .item_value     (item_value),
        .done           (done),
        .status         (status),
        .found_position (found_position),
        .read_value     (read_value)
    );

    pal_list_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .position       (position),
        .item_value     (item_value),
        .done           (done),
        .status         (status),
        .found_position (found_position),
        .read_value     (read_value),
        .mismatches     (mismatches),
        .in_flight      (in_flight)
    );

    always #4ns clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[positional_array_list] ERROR");
            $finish;
        end
    end

    task automatic hold_off(int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    task automatic issue(logic [OP_W-1:0] op, logic [POS_W-1:0] pos, logic [DATA_W-1:0] val);
        @(negedge clk);
        start      <= 1'b1;
        operation  <= op;
        position   <= pos;
        item_value <= val;
        do
            @(posedge clk);
        while (busy);
    endtask

    // hold the sender until every result is back
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (in_flight != 0)
            @(negedge clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        if ($urandom_range(0, 1) == 0)
            return value_pool[$urandom_range(0, 11)];
        return $urandom();
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        if ($urandom_range(0, 99) < 85)
            return POS_W'($urandom_range(1, DEPTH));
        return POS_W'($urandom_range(0, 15));
    endfunction

    function automatic logic [OP_W-1:0] pick_operation();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return OP_INSERT;
        if (r < 45)
            return OP_DELETE;
        if (r < 53)
            return OP_REVERSE;
        if (r < 75)
            return OP_SEARCH;
        if (r < 95)
            return OP_READ;
        return OP_W'($urandom_range(5, 7));
    endfunction

    initial
    begin
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'h8000_0000;
        value_pool[2] = 32'h7FFF_FFFF;
        value_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < 12; i++)
            value_pool[i] = $urandom();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        issue(OP_SEARCH,  4'd0,  32'h0000_0000);
        issue(OP_READ,    4'd1,  32'h0000_0000);
        issue(OP_INSERT,  4'd1,  32'h8000_0000);
        issue(OP_INSERT,  4'd8,  32'h7FFF_FFFF);
        issue(OP_INSERT,  4'd4,  32'h5A5A_A5A5);
        issue(OP_INSERT,  4'd0,  32'h0000_1234);
        issue(OP_INSERT,  4'd9,  32'h0000_5678);
        issue(OP_INSERT,  4'd15, 32'hFFFF_FFFF);
        issue(OP_READ,    4'd8,  32'h0000_0000);
        issue(OP_READ,    4'd0,  32'hFFFF_FFFF);
        issue(OP_READ,    4'd15, 32'h0000_0000);
        issue(OP_SEARCH,  4'd15, 32'h8000_0000);
        issue(OP_SEARCH,  4'd3,  32'hDEAD_BEEF);
        issue(OP_REVERSE, 4'd7,  32'hFFFF_FFFF);
        issue(OP_READ,    4'd1,  32'h0000_0000);
        issue(OP_DELETE,  4'd8,  32'h0000_0000);
        issue(OP_DELETE,  4'd1,  32'h0000_0000);
        issue(OP_DELETE,  4'd0,  32'h0000_0000);
        issue(OP_DELETE,  4'd9,  32'h0000_0000);
        issue(3'd5,       4'd2,  32'h1357_9BDF);
        issue(3'd6,       4'd15, 32'hFFFF_FFFF);
        issue(3'd7,       4'd0,  32'h0000_0000);
        issue(OP_SEARCH,  4'd0,  32'h7FFF_FFFF);
        issue(OP_INSERT,  4'd2,  32'h0F0F_0F0F);
        issue(OP_READ,    4'd2,  32'h0000_0000);
        drain();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n < RANDOM_ITEMS - CALM_ITEMS)
            begin
                if ($urandom_range(0, 99) < 25)
                    hold_off($urandom_range(1, 4));
                if ($urandom_range(0, 99) < 2)
                    drain();
            end
            issue(pick_operation(), pick_position(), pick_value());
        end

        drain();
        repeat (DEPTH + 4) @(posedge clk);
        if (mismatches == 0 && in_flight == 0)
            $display("[positional_array_list] OK");
        else
            $display("[positional_array_list] ERROR");
        $finish;
    end

endmodule
